// ----- rtl/itda_pkg.sv -----
// ----------------------------------------------------------------------------
// itda_pkg: shared types and constants for the decimal text converter
// sequencer states and the ascii codes that the converter emits
// ----------------------------------------------------------------------------
package itda_pkg;

  // ascii codes
  localparam logic [7:0] DIGIT_ZERO = 8'd48;
  localparam logic [7:0] MINUS_SIGN = 8'd45;

  // bits shifted through the bcd unit per cycle
  localparam int BITS_PER_STEP = 4;

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_CONV = 3'b010,
    ST_EMIT = 3'b100
  } state_t;

endpackage

// ----- rtl/int_to_decimal_ascii.sv -----
// ----------------------------------------------------------------------------
// int_to_decimal_ascii: signed integer to decimal ascii text
// converts one two's-complement value into its decimal characters, most
// significant first, with a leading minus sign for negative values
// ----------------------------------------------------------------------------
// usage
//   input: drive in_value and raise start; the beat is taken at a rising edge
//   with start high and busy low. busy drops in the cycle that carries the
//   last character, so the next beat can be taken at the edge ending it.
//   output: each character is on out_character / out_last for one cycle,
//   marked by out_valid. out_last flags the final character. the receiver
//   cannot stall, so every strobed beat is consumed at the edge ending it.
// timing
//   a negative value gives its minus sign in the cycle after the input beat.
//   the magnitude then runs through a shared double-dabble unit, four bits
//   per cycle. the bcd word is then shifted out one digit position per
//   cycle; leading zero positions are shifted out too but emit nothing.
//   busy stays high through the conversion and the emitting of digits, so
//   a new number is taken only once the last one has been sent out.
// reset
//   rst_n is synchronous and active low; it returns the sequencer to idle and
//   drops out_valid. nothing is kept from one number to the next.
// ----------------------------------------------------------------------------
module int_to_decimal_ascii #(
  parameter int VALUE_WIDTH = 32
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  output logic                          busy,
  input  logic signed [VALUE_WIDTH-1:0] in_value,
  output logic                          out_valid,
  output logic [7:0]                    out_character,
  output logic                          out_last
);

  // decimal digit positions needed for 2^(VALUE_WIDTH-1) (1233/4096 ~ log10 2)
  localparam int NDIG   = (VALUE_WIDTH * 1233) / 4096 + 1;
  localparam int BPS    = itda_pkg::BITS_PER_STEP;
  localparam int STEPS  = (VALUE_WIDTH + BPS - 1) / BPS;
  localparam int PAD_W  = STEPS * BPS;
  localparam int BCD_W  = NDIG * 4;
  localparam int SR_W   = BCD_W + PAD_W;
  localparam int CNT_MX = (STEPS > NDIG) ? STEPS : NDIG;
  localparam int CNT_W  = $clog2(CNT_MX + 1);

  itda_pkg::state_t   state_r, state_nxt;
  logic [SR_W-1:0]    sr_r, sr_nxt;         // {bcd digits, binary still to shift}
  logic [CNT_W-1:0]   cnt_r, cnt_nxt;       // steps left, then positions left
  logic               started_r, started_nxt; // a digit has been emitted
  logic               out_valid_r, out_valid_nxt;
  logic [7:0]         out_char_r, out_char_nxt;
  logic               out_last_r, out_last_nxt;

  logic                   accept;
  logic                   neg;
  logic [VALUE_WIDTH-1:0] mag;
  logic [SR_W-1:0]        dab;              // shared double-dabble step
  logic [3:0]             top_digit;

  assign busy      = (state_r != itda_pkg::ST_IDLE);
  assign accept    = start && !busy;
  assign neg       = in_value[VALUE_WIDTH-1];
  // magnitude at full width: the most negative value wraps to 2^(W-1) unsigned
  assign mag       = neg ? (~in_value + 1'b1) : in_value;
  assign top_digit = sr_r[SR_W-1 -: 4];

  // four add-3-then-shift rounds over all bcd digits in parallel
  always_comb begin
    dab = sr_r;
    for (int r = 0; r < BPS; r++) begin
      for (int d = 0; d < NDIG; d++) begin
        if (dab[PAD_W + 4*d +: 4] >= 4'd5) begin
          dab[PAD_W + 4*d +: 4] = dab[PAD_W + 4*d +: 4] + 4'd3;
        end
      end
      dab = {dab[SR_W-2:0], 1'b0};
    end
  end

  always_comb begin
    state_nxt     = state_r;
    sr_nxt        = sr_r;
    cnt_nxt       = cnt_r;
    started_nxt   = started_r;
    out_valid_nxt = 1'b0;
    out_char_nxt  = out_char_r;
    out_last_nxt  = out_last_r;
    case (state_r)
      itda_pkg::ST_IDLE: begin
        if (accept) begin
          // load magnitude below an empty bcd field, zero padded on top
          sr_nxt        = SR_W'(mag);
          cnt_nxt       = CNT_W'(STEPS);
          started_nxt   = 1'b0;
          // sign goes out right away, it is never the last character
          out_valid_nxt = neg;
          out_char_nxt  = itda_pkg::MINUS_SIGN;
          out_last_nxt  = 1'b0;
          state_nxt     = itda_pkg::ST_CONV;
        end
      end
      itda_pkg::ST_CONV: begin
        sr_nxt  = dab;
        cnt_nxt = cnt_r - 1'b1;
        if (cnt_r == CNT_W'(1)) begin
          cnt_nxt   = CNT_W'(NDIG);
          state_nxt = itda_pkg::ST_EMIT;
        end
      end
      itda_pkg::ST_EMIT: begin
        sr_nxt  = {sr_r[SR_W-5:0], 4'd0};
        cnt_nxt = cnt_r - 1'b1;
        // skip leading zeros, but the units position always prints
        if (started_r || (top_digit != 4'd0) || (cnt_r == CNT_W'(1))) begin
          started_nxt   = 1'b1;
          out_valid_nxt = 1'b1;
          out_char_nxt  = itda_pkg::DIGIT_ZERO + {4'd0, top_digit};
          out_last_nxt  = (cnt_r == CNT_W'(1));
        end
        if (cnt_r == CNT_W'(1)) begin
          state_nxt = itda_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = itda_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= itda_pkg::ST_IDLE;
      out_valid_r <= 1'b0;
      started_r   <= 1'b0;
      cnt_r       <= '0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      started_r   <= started_nxt;
      cnt_r       <= cnt_nxt;
    end
  end

  // payload, no reset needed
  always_ff @(posedge clk) begin
    sr_r       <= sr_nxt;
    out_char_r <= out_char_nxt;
    out_last_r <= out_last_nxt;
  end

  assign out_valid     = out_valid_r;
  assign out_character = out_char_r;
  assign out_last      = out_last_r;

endmodule
